@@ rtl/core/utf8t_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 transcoder package
// Payload structs, result kinds, configuration indexes and the job record
// that travels from the byte decoder to the result sequencer.
// ---------------------------------------------------------------------------
package utf8t_pkg;

  // Input beat: one UTF-8 byte with its end-of-string flag
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [20:0] code_unit;
    logic [1:0]  result_kind;
    logic [31:0] unit_count;
    logic        last;
  } out_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_UNIT  = 2'd0;
  localparam kind_t KIND_DONE  = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OUTPUT_FORMAT = 1'b0;
  localparam cfg_idx_t CFG_EMIT_UNITS    = 1'b1;

  typedef struct packed {
    logic output_format;  // 0 UTF-16, 1 UTF-32
    logic emit_units;     // 0 status only
  } cfg_t;

  // Work for the result sequencer caused by one byte: up to two units,
  // then an optional status
  typedef struct packed {
    logic [1:0]  n_units;
    logic [20:0] unit0;
    logic [20:0] unit1;
    logic        has_status;
    kind_t       status_kind;
    logic [31:0] count;
  } job_t;

  // Byte classes and limits
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] LEAD2_MIN    = 8'hC2;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD4_MAX    = 8'hF4;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_ED      = 8'hED;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_F4      = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN   = 8'hA0;
  localparam logic [7:0] ED_SEC_MAX   = 8'h9F;
  localparam logic [7:0] F0_SEC_MIN   = 8'h90;
  localparam logic [7:0] F4_SEC_MAX   = 8'h8F;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

endpackage
`default_nettype wire

@@ rtl/core/utf8_transcoder_utf16_utf32_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 / UTF-32 transcoder, top level
// Strict streaming UTF-8 validation and conversion with per-string status.
// ---------------------------------------------------------------------------
// Usage:
//   Input: push one UTF-8 byte per beat with in_push while in_full is low;
//   end_of_string marks the final byte of each string.
//   Results: while out_empty is low the oldest result sits on out_data; take
//   it with out_pop. Each string yields its code units (UTF-16 or UTF-32 by
//   output_format, none when emit_units is 0) then one done status with the
//   unit count, or one error status at the first fault, after which the
//   rest of the string is dropped.
//   Throughput: one byte per cycle in while in_full is low, one result per
//   cycle out while out_pop is high. A byte is decoded in the cycle it is
//   accepted; its job passes the job queue, then the output register.
//   Extra beats (surrogate pair, status) wait in the JOB_DEPTH-entry job queue.
//   Stall: when the receiver holds off pop, the output register and the job
//   queue fill and in_full rises; nothing is lost.
//   Reset (synchronous, rst_n low): string state and queue cleared,
//   output_format = UTF-16, emit_units = 1. No clearing pass.
//   Configuration: cfg_we writes register cfg_index from cfg_wdata; write
//   only while the block is idle.
// ---------------------------------------------------------------------------
module utf8_transcoder_utf16_utf32_top #(
  parameter int COUNT_BITS = 32,
  parameter int JOB_DEPTH  = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Byte channel
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire utf8t_pkg::in_t      in_data,
  // Result channel
  output logic                     out_empty,
  input  wire logic                out_pop,
  output utf8t_pkg::out_t          out_data,
  // Configuration writes
  input  wire logic                cfg_we,
  input  wire utf8t_pkg::cfg_idx_t cfg_index,
  input  wire logic                cfg_wdata
);
  import utf8t_pkg::*;

  cfg_t cfg_r;
  logic in_acc;
  logic job_push;
  job_t job;
  logic q_full, q_empty, q_pop;
  job_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_format <= 1'b0;
      cfg_r.emit_units    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_FORMAT: cfg_r.output_format <= cfg_wdata;
        CFG_EMIT_UNITS:    cfg_r.emit_units    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the job queue has room for its work
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  utf8t_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .job_push (job_push),
    .job      (job)
  );

  utf8t_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  utf8t_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/utf8t_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 byte decoder
// Assembles and validates sequences, counts units and builds one job per
// byte that has results.
// ---------------------------------------------------------------------------
module utf8t_front #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_acc,
  input  wire utf8t_pkg::in_t  in_data,
  input  wire utf8t_pkg::cfg_t cfg,
  output logic                 job_push,
  output utf8t_pkg::job_t      job
);
  import utf8t_pkg::*;

  localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [1:0]       pend_r,    pend_nxt;
  logic [7:0]       lead_r,    lead_nxt;
  logic             second_r,  second_nxt;
  logic [20:0]      accum_r,   accum_nxt;
  logic             discard_r, discard_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;

  logic [7:0]   b;
  logic         eos;
  logic         bad;
  logic         emit;
  logic [20:0]  cp;
  logic         surr;
  logic [20:0]  v;
  logic [1:0]   n_add;
  logic [CNT_W:0] cnt_sum;
  logic [CNT_W-1:0] cnt_new;

  assign b   = in_data.byte_value;
  assign eos = in_data.end_of_string;

  // Surrogate split and saturating count
  assign surr    = emit && !cfg.output_format && (cp >= SUPP_BASE);
  assign v       = cp - SUPP_BASE;
  assign n_add   = emit ? (surr ? 2'd2 : 2'd1) : 2'd0;
  assign cnt_sum = {1'b0, cnt_r} + (CNT_W+1)'(n_add);
  assign cnt_new = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];

  always_comb begin
    pend_nxt    = pend_r;
    lead_nxt    = lead_r;
    second_nxt  = second_r;
    accum_nxt   = accum_r;
    discard_nxt = discard_r;
    cnt_nxt     = cnt_r;
    bad         = 1'b0;
    emit        = 1'b0;
    cp          = '0;
    job         = '0;

    if (discard_r) begin
      // Drop the rest of a failed string
      if (eos) begin
        discard_nxt = 1'b0;
        pend_nxt    = '0;
        lead_nxt    = '0;
        second_nxt  = 1'b0;
        accum_nxt   = '0;
        cnt_nxt     = '0;
      end
    end else begin
      if (pend_r == 2'd0) begin
        if (!b[7]) begin
          emit = 1'b1;
          cp   = {13'd0, b};
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          pend_nxt  = 2'd1;
          accum_nxt = {16'd0, b[4:0]};
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          pend_nxt  = 2'd2;
          accum_nxt = {17'd0, b[3:0]};
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          pend_nxt  = 2'd3;
          accum_nxt = {18'd0, b[2:0]};
        end else begin
          bad = 1'b1;
        end
        lead_nxt   = b;
        second_nxt = 1'b0;
      end else begin
        if ((b & CONT_MASK) != CONT_TAG) begin
          bad = 1'b1;
        end else if (!second_r &&
                     ((lead_r == LEAD_E0 && b < E0_SEC_MIN) ||
                      (lead_r == LEAD_ED && b > ED_SEC_MAX) ||
                      (lead_r == LEAD_F0 && b < F0_SEC_MIN) ||
                      (lead_r == LEAD_F4 && b > F4_SEC_MAX))) begin
          bad = 1'b1;
        end else begin
          second_nxt = 1'b1;
          accum_nxt  = {accum_r[14:0], b[5:0]};
          pend_nxt   = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            emit = 1'b1;
            cp   = {accum_r[14:0], b[5:0]};
          end
        end
      end

      // A string may not end inside a sequence
      if (!bad && eos && pend_nxt != 2'd0) begin
        bad = 1'b1;
      end

      cnt_nxt = cnt_new;
      if (cfg.emit_units) begin
        job.n_units = n_add;
      end
      job.unit0 = surr ? {5'd0, HI_SURR_TAG, v[19:10]} : cp;
      job.unit1 = {5'd0, LO_SURR_TAG, v[9:0]};

      if (bad || eos) begin
        job.has_status  = 1'b1;
        job.status_kind = bad ? KIND_ERROR : KIND_DONE;
        job.count       = bad ? 32'd0 : 32'(cnt_new);
        discard_nxt     = bad && !eos;
        pend_nxt        = '0;
        lead_nxt        = '0;
        second_nxt      = 1'b0;
        accum_nxt       = '0;
        cnt_nxt         = '0;
      end
    end
  end

  assign job_push = in_acc && (job.n_units != 2'd0 || job.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      lead_r    <= '0;
      second_r  <= 1'b0;
      accum_r   <= '0;
      discard_r <= 1'b0;
      cnt_r     <= '0;
    end else if (in_acc) begin
      pend_r    <= pend_nxt;
      lead_r    <= lead_nxt;
      second_r  <= second_nxt;
      accum_r   <= accum_nxt;
      discard_r <= discard_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  a_discard_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> pend_r == 2'd0)
    else $error("discarding with a sequence still open");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eos) |=> (pend_r == 2'd0 && cnt_r == '0 && !discard_r))
    else $error("string state not cleared at end of string");

endmodule
`default_nettype wire

@@ rtl/core/utf8t_jobq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Job queue
// Short register queue that decouples the byte decoder from the result
// sequencer.
// ---------------------------------------------------------------------------
module utf8t_jobq #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire utf8t_pkg::job_t  push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output utf8t_pkg::job_t       head
);
  import utf8t_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_lost_job: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule
`default_nettype wire

@@ rtl/core/utf8t_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Result sequencer
// Walks each job's units and status into the output register, one result per
// cycle while that register is empty or being popped.
// ---------------------------------------------------------------------------
module utf8t_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire utf8t_pkg::job_t q_head,
  output logic                 q_pop,
  input  wire logic            out_pop,
  output logic                 out_empty,
  output utf8t_pkg::out_t      out_data
);
  import utf8t_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       ov_r;
  out_t       out_r;
  out_t       cur;
  logic [1:0] total;
  logic       final_beat;
  logic       load;

  assign total      = q_head.n_units + {1'b0, q_head.has_status};
  assign final_beat = (idx_r == total - 2'd1);
  assign load       = !q_empty && (!ov_r || out_pop);
  assign q_pop      = load && final_beat;
  assign idx_nxt    = final_beat ? 2'd0 : idx_r + 2'd1;

  always_comb begin
    cur = '0;
    if (idx_r < q_head.n_units) begin
      cur.code_unit   = (idx_r == 2'd0) ? q_head.unit0 : q_head.unit1;
      cur.result_kind = KIND_UNIT;
    end else begin
      cur.result_kind = q_head.status_kind;
      cur.unit_count  = q_head.count;
      cur.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
        ov_r  <= 1'b1;
      end else if (out_pop) begin
        ov_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= cur;
    end
  end

  assign out_empty = !ov_r;
  assign out_data  = out_r;

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.last) |-> out_r.result_kind != KIND_UNIT)
    else $error("unit result flagged as last");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < total)
    else $error("sequencer index beyond job");

endmodule
`default_nettype wire

@@ tb/tb_utf8_transcoder_utf16_utf32_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the UTF-8 to UTF-16 / UTF-32 transcoder
// Pushes UTF-8 byte beats through the input queue port and pops result beats
// with random gaps on both sides. A directed table covers the byte-class
// extremes and each kind of fault. Random strings follow under every output
// setting, mostly well-formed with random code points and some corrupted or
// pure noise. Every popped beat is compared field by field with the oldest
// prediction from a cycle-free decoder kept in this file.
// ---------------------------------------------------------------------------
module tb_utf8_transcoder_utf16_utf32_top;
  import utf8t_pkg::*;

  // Cycles to let the result path settle after the last expected beat
  // (output register plus a JOB_DEPTH-deep job queue, with margin)
  localparam int DRAIN_CYCLES = 12;
  // Random byte budget per configuration phase
  localparam int PHASE_BYTES  = 32;

  // Code points on class boundaries and around the surrogate hole
  localparam logic [20:0] POINT_EDGES [10] = '{
    21'h00000, 21'h0007F, 21'h00080, 21'h007FF, 21'h00800,
    21'h0D7FF, 21'h0E000, 21'h0FFFF, 21'h10000, 21'h10FFFF
  };

  // One row of the directed table; a pinned row causes exactly one result,
  // typed in here, that replaces the decoder's prediction
  typedef struct {
    in_t  beat;
    bit   pinned;
    out_t pinned_res;
  } stim_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_push   = 1'b0;
  logic     in_full;
  in_t      in_data   = '0;
  logic     out_empty;
  logic     out_pop   = 1'b0;
  out_t     out_data;
  logic     cfg_we    = 1'b0;
  cfg_idx_t cfg_index = CFG_OUTPUT_FORMAT;
  logic     cfg_wdata = 1'b0;

  // Decoder copy: settings and per-string state, at their reset values
  bit          fmt_utf32     = 1'b0;
  bit          emit_on       = 1'b1;
  logic [1:0]  seq_left      = '0;
  logic [7:0]  seq_lead      = '0;
  bit          seq_second_ok = 1'b0;
  logic [20:0] cp_acc        = '0;
  bit          dropping      = 1'b0;
  logic [31:0] str_units     = '0;

  out_t        expected_results [$];
  int unsigned mismatches     = 0;
  int unsigned beats_accepted = 0;
  bit          calm           = 1'b0;  // no gaps on either side while set

  // Directed table, walked in order under the reset settings (UTF-16, units on)
  stim_row_t directed_rows [25] = '{
    // smallest ASCII byte, mid-string
    '{'{8'h00, 1'b0}, 1'b1, '{21'h0, KIND_UNIT, 32'd0, 1'b0}},
    // largest ASCII byte closes the string: unit then done
    '{'{8'h7F, 1'b1}, 1'b0, '0},
    // stray continuation byte as lead
    '{'{8'h80, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    // overlong lead, not on the final byte: the rest of the string is dropped
    '{'{8'hC1, 1'b0}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'h41, 1'b1}, 1'b0, '0},
    // leads beyond the U+10FFFF limit
    '{'{8'hFF, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'hF5, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    // second-byte range limits: overlong E0, surrogate ED, overlong F0, F4 high
    '{'{8'hE0, 1'b0}, 1'b0, '0},
    '{'{8'h9F, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'hED, 1'b0}, 1'b0, '0},
    '{'{8'hA0, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h8F, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'hF4, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    // string ends inside a sequence
    '{'{8'hC3, 1'b1}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    // non-continuation byte where one is due, then dropping until the end
    '{'{8'hE2, 1'b0}, 1'b0, '0},
    '{'{8'h28, 1'b0}, 1'b1, '{21'h0, KIND_ERROR, 32'd0, 1'b1}},
    '{'{8'h41, 1'b1}, 1'b0, '0},
    // U+10FFFF: surrogate pair and a count of two
    '{'{8'hF4, 1'b0}, 1'b0, '0},
    '{'{8'h8F, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b1}, 1'b0, '0},
    // smallest two-byte code point
    '{'{8'hC2, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1}, 1'b0, '0}
  };

  utf8_transcoder_utf16_utf32_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder
  // ---------------------------------------------------------------------------

  function automatic out_t make_beat(input logic [20:0] unit, input kind_t kind,
                                     input logic [31:0] count, input logic last);
    out_t b;
    b.code_unit   = unit;
    b.result_kind = kind;
    b.unit_count  = count;
    b.last        = last;
    return b;
  endfunction

  // Saturate rather than wrap
  function automatic void bump_count();
    if (str_units != '1) str_units++;
  endfunction

  function automatic void clear_string();
    seq_left      = '0;
    seq_lead      = '0;
    seq_second_ok = 1'b0;
    cp_acc        = '0;
    str_units     = '0;
  endfunction

  // Queue the units of one finished code point; count them even when muted
  function automatic void emit_point(input logic [20:0] cp);
    logic [20:0] off;
    if (!fmt_utf32 && cp >= SUPP_BASE) begin
      off = cp - SUPP_BASE;
      if (emit_on) begin
        expected_results.push_back(
          make_beat({5'd0, HI_SURR_TAG, off[19:10]}, KIND_UNIT, '0, 1'b0));
        expected_results.push_back(
          make_beat({5'd0, LO_SURR_TAG, off[9:0]}, KIND_UNIT, '0, 1'b0));
      end
      bump_count();
      bump_count();
    end else begin
      if (emit_on) expected_results.push_back(make_beat(cp, KIND_UNIT, '0, 1'b0));
      bump_count();
    end
  endfunction

  // Advance the decoder by one accepted byte; return how many beats it queued
  function automatic int unsigned decode_byte(input in_t beat);
    logic [7:0]  b;
    bit          eos;
    bit          bad;
    int unsigned depth_then;
    b          = beat.byte_value;
    eos        = beat.end_of_string;
    bad        = 1'b0;
    depth_then = expected_results.size();

    // After a fault, swallow everything up to the string's final byte
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        clear_string();
      end
      return 0;
    end

    if (seq_left == 0) begin
      if (b < CONT_TAG) begin
        emit_point({13'd0, b});
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        seq_left = 2'd1;
        cp_acc   = {16'd0, b[4:0]};
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        seq_left = 2'd2;
        cp_acc   = {17'd0, b[3:0]};
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        seq_left = 2'd3;
        cp_acc   = {18'd0, b[2:0]};
      end else begin
        bad = 1'b1;
      end
      seq_lead      = b;
      seq_second_ok = 1'b0;
    end else begin
      if ((b & CONT_MASK) != CONT_TAG) begin
        bad = 1'b1;
      end else if (!seq_second_ok &&
                   ((seq_lead == LEAD_E0 && b < E0_SEC_MIN) ||
                    (seq_lead == LEAD_ED && b > ED_SEC_MAX) ||
                    (seq_lead == LEAD_F0 && b < F0_SEC_MIN) ||
                    (seq_lead == LEAD_F4 && b > F4_SEC_MAX))) begin
        bad = 1'b1;
      end else begin
        seq_second_ok = 1'b1;
        cp_acc        = {cp_acc[14:0], b[5:0]};
        seq_left      = seq_left - 2'd1;
        if (seq_left == 0) emit_point(cp_acc);
      end
    end

    // Truncated sequence
    if (!bad && eos && seq_left != 0) bad = 1'b1;

    if (bad) begin
      expected_results.push_back(make_beat('0, KIND_ERROR, '0, 1'b1));
      clear_string();
      dropping = !eos;
    end else if (eos) begin
      expected_results.push_back(make_beat('0, KIND_DONE, str_units, 1'b1));
      clear_string();
    end
    return expected_results.size() - depth_then;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [20:0] pick_point();
    logic [20:0] cp;
    if ($urandom_range(0, 4) == 0) return POINT_EDGES[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0: cp = 21'($urandom_range(21'h0, 21'h7F));
      1: cp = 21'($urandom_range(21'h80, 21'h7FF));
      2: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        // step out of the surrogate hole into U+F800..U+FFFF
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void encode_point(input logic [20:0] cp, ref logic [7:0] q [$]);
    if (cp < 21'h80) begin
      q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      q.push_back({3'b110, cp[10:6]});
      q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      q.push_back({4'b1110, cp[15:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end else begin
      q.push_back({5'b11110, cp[20:18]});
      q.push_back({2'b10, cp[17:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Present one beat at a falling edge and hold it until the block takes it.
  // Push is only ever assigned once per falling edge: it stays high between
  // back-to-back beats and is lowered only for a gap or at the end of a phase.
  task automatic send_beat(input in_t beat, input bit pinned, input out_t pinned_res);
    int unsigned gap;
    int unsigned n;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_push <= 1'b0;
      in_data <= in_t'($urandom);  // junk on the bus while idle
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_accepted++;
    n = decode_byte(beat);
    // A pinned row replaces the decoder's beat by the typed-in one
    if (pinned) begin
      repeat (n) void'(expected_results.pop_back());
      expected_results.push_back(pinned_res);
    end
  endtask

  // Drop push, wait for every expected beat, then let the block go quiet
  task automatic finish_phase();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers on consecutive edges, write enable held high
  task automatic write_settings(input bit utf32, input bit units);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUTPUT_FORMAT;
    cfg_wdata <= utf32;
    @(negedge clk);
    cfg_index <= CFG_EMIT_UNITS;
    cfg_wdata <= units;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fmt_utf32 = utf32;
    emit_on   = units;
  endtask

  // One random string: mostly well-formed, some corrupted, some pure noise
  task automatic send_string();
    logic [7:0]  str_bytes [$];
    int unsigned style;
    int unsigned pos;
    in_t         beat;
    style = $urandom_range(0, 9);
    if (style == 9) begin
      repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) encode_point(pick_point(), str_bytes);
      if (style >= 7) begin
        if ($urandom_range(0, 1) == 0 && str_bytes.size() > 1) begin
          // cut the string short, usually inside its last sequence
          void'(str_bytes.pop_back());
        end else begin
          pos = $urandom_range(0, str_bytes.size() - 1);
          str_bytes[pos] = 8'($urandom_range(0, 255));
        end
      end
    end
    foreach (str_bytes[i]) begin
      beat.byte_value    = str_bytes[i];
      beat.end_of_string = (i == str_bytes.size() - 1);
      send_beat(beat, 1'b0, '0);
    end
  endtask

  task automatic random_phase(input bit utf32, input bit units, input bit quiet);
    int unsigned start;
    write_settings(utf32, units);
    calm  = quiet;
    start = beats_accepted;
    while (beats_accepted - start < PHASE_BYTES) send_string();
    finish_phase();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls, check each beat taken
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold != 0) begin
        out_pop <= 1'b0;
        hold--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: code_unit %0h kind %0d count %0d last %0b",
               out_data.code_unit, out_data.result_kind, out_data.unit_count,
               out_data.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.code_unit !== want.code_unit) begin
          $error("code_unit: expected %0h, got %0h", want.code_unit, out_data.code_unit);
          mismatches++;
        end
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d",
                 want.result_kind, out_data.result_kind);
          mismatches++;
        end
        if (out_data.unit_count !== want.unit_count) begin
          $error("unit_count: expected %0d, got %0d", want.unit_count, out_data.unit_count);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset low, then release it on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset settings
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].pinned_res);
    finish_phase();

    // Random strings under every setting; one phase runs without any gaps
    random_phase(1'b1, 1'b1, 1'b0);
    random_phase(1'b0, 1'b0, 1'b1);
    random_phase(1'b1, 1'b0, 1'b0);
    random_phase(1'b0, 1'b1, 1'b0);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
